// ===== hw/rtl/cmfr_pkg.sv =====
// Shared types and constants of the DSP command engine and frame ring.
// No dependencies; imported by every module of the block.
package cmfr_pkg;

    // Fixed field widths of the command and result transfers
    localparam int ADDR_W   = 16;
    localparam int VAL_W    = 24;
    localparam int UPPER_W  = 16;
    localparam int FRAMES_W = 16;
    localparam int DROP_W   = 32;
    localparam int BASE_W   = 40;

    // Remainder unit: dividend holds a ring position plus up to a frame count
    localparam int DVD_W = 25;
    localparam int DVS_W = 24;

    typedef logic [2:0] t_action;
    localparam t_action ACT_READ    = 3'd0;
    localparam t_action ACT_WRITE   = 3'd1;
    localparam t_action ACT_SETTING = 3'd2;
    localparam t_action ACT_VERSION = 3'd3;
    localparam t_action ACT_RESET   = 3'd4;
    localparam t_action ACT_TICK    = 3'd5;

    typedef logic [1:0] t_space;
    localparam t_space SPC_P   = 2'd0;
    localparam t_space SPC_X   = 2'd1;
    localparam t_space SPC_Y   = 2'd2;
    localparam t_space SPC_BAD = 2'd3;

    typedef logic [3:0] t_setting;
    localparam t_setting SET_ENABLE = 4'd0;
    localparam t_setting SET_DELTA  = 4'd1;
    localparam t_setting SET_NUMBER = 4'd2;
    localparam t_setting SET_INFORM = 4'd3;
    localparam t_setting SET_PERIOD = 4'd4;
    localparam t_setting SET_SIZE   = 4'd5;
    localparam t_setting SET_TAIL   = 4'd6;
    localparam t_setting SET_HEAD   = 4'd7;
    localparam t_setting SET_DROPS  = 4'd8;
    localparam t_setting SET_BASE   = 4'd9;

    localparam logic [VAL_W-1:0] RESET_X0    = 24'h000100;
    localparam logic [VAL_W-1:0] MIN_VERSION = 24'h550103;

    // Command from the controller to the frame ring
    typedef struct packed {
        logic                set_wr;
        t_setting            setting;
        logic [VAL_W-1:0]    value;
        logic [UPPER_W-1:0]  upper;
        logic                tick;
        logic [FRAMES_W-1:0] frames;
    } t_ring_cmd;

    // Status from the frame ring back to the controller
    typedef struct packed {
        logic              done;
        logic [VAL_W-1:0]  head;
        logic [VAL_W-1:0]  tail;
        logic [DROP_W-1:0] drops;
    } t_ring_stat;

endpackage

// ===== hw/rtl/cmfr_mem.sv =====
// Word memory holding the P, X and Y spaces back to back.
// One write port, one read port with registered read data; uses cmfr_pkg.
module cmfr_mem
    import cmfr_pkg::*;
#(
    parameter int DEPTH  = 12288,
    parameter int IDX_W  = 14,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [IDX_W-1:0]  i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write one word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read one word into the registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/cmfr_rem.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle.
// Shared by the frame ring for both wrap computations; uses cmfr_pkg.
module cmfr_rem
    import cmfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic [DVS_W-1:0] n_rem;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        shifted = {r_rem, r_dvd[DVD_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        if (shifted >= {1'b0, r_dvs}) begin
            n_rem = diff[DVS_W-1:0];
        end else begin
            n_rem = shifted[DVS_W-1:0];
        end
    end

    // Control: count the steps and pulse done after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then advance one bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/cmfr_ring.sv =====
// Frame-ring registers and the frame-tick sequencer.
// Computes the head advance in closed form through cmfr_rem; uses cmfr_pkg.
module cmfr_ring
    import cmfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ring_cmd  i_cmd,
    output t_ring_stat o_stat
);

    typedef enum logic [4:0] {
        R_IDLE = 5'b00001,
        R_MOD1 = 5'b00010,
        R_STEP = 5'b00100,
        R_MOD2 = 5'b01000,
        R_DONE = 5'b10000
    } t_rstate;

    t_rstate             r_state, n_state;
    logic [VAL_W-1:0]    r_enable, r_delta, r_slots, r_inform;
    logic [VAL_W-1:0]    r_period, r_size, r_tail, r_head;
    logic [DROP_W-1:0]   r_drops;
    logic [BASE_W-1:0]   r_base;
    logic [FRAMES_W-1:0] r_frames;
    logic [VAL_W-1:0]    r_next;

    logic                rem_start;
    logic [DVD_W-1:0]    rem_dividend;
    logic                rem_done;
    logic [DVS_W-1:0]    rem_out;
    logic [VAL_W-1:0]    room;
    logic [VAL_W-1:0]    adv;

    cmfr_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (rem_dividend),
        .i_divisor  (r_slots),
        .o_done     (rem_done),
        .o_rem      (rem_out)
    );

    // Free slots ahead of the first new head; a tail past the ring never blocks
    always_comb begin
        if (r_tail >= r_next) begin
            room = r_tail - r_next;
        end else begin
            room = r_tail - r_next + r_slots;
        end
        if (r_tail >= r_slots || {8'b0, r_frames} < room) begin
            adv = VAL_W'(r_frames);
        end else begin
            adv = room;
        end
    end

    // Sequence the tick
    always_comb begin
        n_state      = r_state;
        rem_start    = 1'b0;
        rem_dividend = DVD_W'(r_head) + 1'b1;
        unique case (r_state)
            R_IDLE: begin
                if (i_cmd.tick) begin
                    if (r_slots == '0) begin
                        n_state = R_DONE;
                    end else begin
                        rem_start = 1'b1;
                        n_state   = R_MOD1;
                    end
                end
            end
            R_MOD1: begin
                if (rem_done) begin
                    n_state = R_STEP;
                end
            end
            R_STEP: begin
                rem_dividend = DVD_W'(r_next) + DVD_W'(adv) - 1'b1;
                if (adv == '0) begin
                    n_state = R_DONE;
                end else begin
                    rem_start = 1'b1;
                    n_state   = R_MOD2;
                end
            end
            R_MOD2: begin
                if (rem_done) begin
                    n_state = R_DONE;
                end
            end
            R_DONE: begin
                n_state = R_IDLE;
            end
            default: begin
                n_state = R_IDLE;
            end
        endcase
    end

    // Hold the frame count of the tick in flight and the first new head position
    always_ff @(posedge i_clk) begin
        if (r_state == R_IDLE && i_cmd.tick) begin
            r_frames <= i_cmd.frames;
        end
        if (r_state == R_MOD1 && rem_done) begin
            r_next <= rem_out;
        end
    end

    // Ring registers: host writes and tick updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= R_IDLE;
            r_enable <= '0;
            r_delta  <= '0;
            r_slots  <= '0;
            r_inform <= '0;
            r_period <= '0;
            r_size   <= '0;
            r_tail   <= '0;
            r_head   <= '0;
            r_drops  <= '0;
            r_base   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cmd.set_wr) begin
                case (i_cmd.setting)
                    SET_ENABLE: r_enable <= i_cmd.value;
                    SET_DELTA:  r_delta  <= i_cmd.value;
                    SET_NUMBER: r_slots  <= i_cmd.value;
                    SET_INFORM: r_inform <= i_cmd.value;
                    SET_PERIOD: r_period <= i_cmd.value;
                    SET_SIZE:   r_size   <= i_cmd.value;
                    SET_TAIL:   r_tail   <= i_cmd.value;
                    SET_HEAD:   r_head   <= i_cmd.value;
                    SET_DROPS:  r_drops  <= DROP_W'(i_cmd.value);
                    SET_BASE:   r_base   <= BASE_W'(i_cmd.value) |
                                            (BASE_W'(i_cmd.upper) << 16);
                    default:    ;
                endcase
            end
            // Zero slots: drop every frame
            if (r_state == R_IDLE && i_cmd.tick && r_slots == '0) begin
                r_drops <= r_drops + DROP_W'(i_cmd.frames);
            end
            // Count frames that found the ring full
            if (r_state == R_STEP) begin
                r_drops <= r_drops + (DROP_W'(r_frames) - DROP_W'(adv));
            end
            if (r_state == R_MOD2 && rem_done) begin
                r_head <= rem_out;
            end
        end
    end

    assign o_stat.done  = (r_state == R_DONE);
    assign o_stat.head  = r_head;
    assign o_stat.tail  = r_tail;
    assign o_stat.drops = r_drops;

endmodule

// ===== hw/rtl/dsp_command_memory_and_frame_ring.sv =====
// DSP command engine: memory reads and writes, ring settings, frame ticks.
// An in-range read answers via the memory read-data register, then the result registers.
// A frame tick runs cmfr_rem not at all with no slots, once if no frame moves, else twice.
// One command at a time; busy is high while a read or tick is in flight.
// After reset the memory is cleared word by word, all P, X and Y words, busy high.
// Results are strobed for one cycle by o_valid; the receiver cannot stall.
module dsp_command_memory_and_frame_ring
    import cmfr_pkg::*;
#(
    parameter int P_DEPTH      = 4096,
    parameter int X_DEPTH      = 4096,
    parameter int Y_DEPTH      = 4096,
    parameter int WORD_BITS    = 24,
    parameter int VERSION_WORD = 5570820
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_action,
    input  logic [1:0]          i_space,
    input  logic [3:0]          i_ring_setting,
    input  logic [ADDR_W-1:0]   i_address,
    input  logic [VAL_W-1:0]    i_word_value,
    input  logic [UPPER_W-1:0]  i_value_upper,
    input  logic [FRAMES_W-1:0] i_frame_count,
    output logic                o_valid,
    output logic                o_kind,
    output logic [2:0]          o_echo_action,
    output logic                o_status,
    output logic [VAL_W-1:0]    o_read_word,
    output logic [VAL_W-1:0]    o_ring_head,
    output logic [VAL_W-1:0]    o_ring_tail,
    output logic [DROP_W-1:0]   o_drop_total
);

    localparam int MEM_W  = (WORD_BITS < VAL_W) ? WORD_BITS : VAL_W;
    localparam int X_BASE = P_DEPTH;
    localparam int Y_BASE = P_DEPTH + X_DEPTH;
    localparam int TOTAL  = P_DEPTH + X_DEPTH + Y_DEPTH;
    localparam int IDX_W  = $clog2(TOTAL);
    localparam logic VERSION_BAD = (VERSION_WORD < int'(MIN_VERSION));
    localparam logic [VAL_W-1:0] VERSION_DATA = VAL_W'(VERSION_WORD);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_TICK  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_clr_idx, n_clr_idx;
    logic               r_valid, n_valid;
    logic               r_kind, n_kind;
    t_action            r_echo, n_echo;
    logic               r_status, n_status;
    logic [VAL_W-1:0]   r_word, n_word;
    logic [VAL_W-1:0]   r_head, n_head;
    logic [VAL_W-1:0]   r_tail, n_tail;
    logic [DROP_W-1:0]  r_drops, n_drops;

    logic               acc;
    logic               in_range;
    logic               y_timeout;
    logic [IDX_W-1:0]   mem_base;
    logic [IDX_W-1:0]   mem_idx;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [MEM_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [MEM_W-1:0]   mem_rdata;
    t_ring_cmd          ring_cmd;
    t_ring_stat         ring_stat;

    cmfr_mem #(
        .DEPTH  (TOTAL),
        .IDX_W  (IDX_W),
        .DATA_W (MEM_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_idx),
        .o_rdata (mem_rdata)
    );

    cmfr_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (ring_cmd),
        .o_stat  (ring_stat)
    );

    assign busy = (r_state != S_IDLE);
    assign acc  = start && !busy;

    // Map space and address onto the shared memory, check bounds
    always_comb begin
        unique case (i_space)
            SPC_P: begin
                in_range = ({1'b0, i_address} < 17'(P_DEPTH));
                mem_base = '0;
            end
            SPC_X: begin
                in_range = ({1'b0, i_address} < 17'(X_DEPTH));
                mem_base = IDX_W'(X_BASE);
            end
            SPC_Y: begin
                in_range = ({1'b0, i_address} < 17'(Y_DEPTH));
                mem_base = IDX_W'(Y_BASE);
            end
            default: begin
                in_range = 1'b0;
                mem_base = '0;
            end
        endcase
        mem_idx   = mem_base + IDX_W'(i_address);
        y_timeout = (i_space == SPC_Y) && ({1'b0, i_address} == 17'(Y_DEPTH));
    end

    // Decode commands and build the next result
    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        mem_we    = 1'b0;
        mem_waddr = r_clr_idx;
        mem_wdata = '0;
        mem_re    = 1'b0;
        n_valid   = 1'b0;
        n_kind    = 1'b0;
        n_echo    = i_action;
        n_status  = 1'b0;
        n_word    = '0;
        n_head    = '0;
        n_tail    = '0;
        n_drops   = '0;
        ring_cmd         = '0;
        ring_cmd.setting = i_ring_setting;
        ring_cmd.value   = i_word_value;
        ring_cmd.upper   = i_value_upper;
        ring_cmd.frames  = i_frame_count;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr_idx == IDX_W'(TOTAL - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_valid = 1'b1;
                    case (i_action)
                        ACT_READ: begin
                            if (y_timeout) begin
                                n_valid = 1'b0;
                            end else if (in_range) begin
                                mem_re  = 1'b1;
                                n_valid = 1'b0;
                                n_state = S_READ;
                            end else begin
                                n_status = 1'b1;
                            end
                        end
                        ACT_WRITE: begin
                            if (in_range) begin
                                mem_we    = 1'b1;
                                mem_waddr = mem_idx;
                                mem_wdata = MEM_W'(i_word_value);
                            end else begin
                                n_status = 1'b1;
                            end
                        end
                        ACT_SETTING: begin
                            ring_cmd.set_wr = 1'b1;
                            n_status        = (i_ring_setting > SET_BASE);
                        end
                        ACT_VERSION: begin
                            n_status = VERSION_BAD;
                            n_word   = VERSION_BAD ? '0 : VERSION_DATA;
                        end
                        ACT_RESET: begin
                            mem_we    = 1'b1;
                            mem_waddr = IDX_W'(X_BASE);
                            mem_wdata = MEM_W'(RESET_X0);
                        end
                        ACT_TICK: begin
                            n_valid       = 1'b0;
                            ring_cmd.tick = 1'b1;
                            n_state       = S_TICK;
                        end
                        default: begin
                            n_status = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_valid = 1'b1;
                n_echo  = ACT_READ;
                n_word  = VAL_W'(mem_rdata);
                n_state = S_IDLE;
            end
            S_TICK: begin
                n_echo = ACT_TICK;
                n_kind = 1'b1;
                if (ring_stat.done) begin
                    n_valid = 1'b1;
                    n_head  = ring_stat.head;
                    n_tail  = ring_stat.tail;
                    n_drops = ring_stat.drops;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_valid   <= n_valid;
        end
    end

    // Result payload registers
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_echo   <= n_echo;
        r_status <= n_status;
        r_word   <= n_word;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_drops  <= n_drops;
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_echo_action = r_echo;
    assign o_status      = r_status;
    assign o_read_word   = r_word;
    assign o_ring_head   = r_head;
    assign o_ring_tail   = r_tail;
    assign o_drop_total  = r_drops;

    // No result may appear while the memory is being cleared
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_valid)
        else $error("result strobed during memory clear");

    // An issued memory read answers through the S_READ state and the result register
    a_read_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |-> ##2 o_valid)
        else $error("memory read produced no result");

    // Ring completion only while a tick is outstanding
    a_ring_done_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_stat.done |-> (r_state == S_TICK))
        else $error("ring finished outside a tick");

    // Ring status results come only from a tick
    a_kind_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind) |-> $past(r_state == S_TICK))
        else $error("ring status result without a tick");

endmodule
